// ===== rtl/twg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_pkg: shared types and constants of the twiddle gain tuner
// Widths, mode and phase codes, register indexes, the item, result, configuration
// and lane command structs, and the saturating gain adder.
// ----------------------------------------------------------------------------
package twg_pkg;

    // sizes
    localparam int NUM_GAINS   = 3;
    localparam int GAIN_WIDTH  = 32;
    localparam int ERROR_WIDTH = 48;
    localparam int INIT_GAINS  = 3;
    localparam int GIDX_W      = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int GIDX_OUT_W  = 2;
    localparam int PHASE_W     = 2;
    localparam int MODE_W      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 2 * SAMPLE_W;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CFG     = 7;

    // floor(x / 10) for a GAIN_WIDTH-bit x as (x * DIV10_MUL) >> DIV10_SHIFT
    localparam int DIV10_SHIFT = GAIN_WIDTH + 3;
    localparam logic [GAIN_WIDTH-1:0] DIV10_MUL =
        GAIN_WIDTH'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

    // item modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_END_INT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_END_EXT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ABORT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONTINUE = 3'd4;

    // next tuning action
    localparam logic [PHASE_W-1:0] ACT_INIT     = 2'd0;
    localparam logic [PHASE_W-1:0] ACT_INCREASE = 2'd1;
    localparam logic [PHASE_W-1:0] ACT_DECREASE = 2'd2;
    localparam logic [PHASE_W-1:0] ACT_REVERT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_P = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_I = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_D = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd6;

    // lane gain operations
    localparam logic [1:0] GOP_NONE = 2'd0;
    localparam logic [1:0] GOP_ADD  = 2'd1;
    localparam logic [1:0] GOP_SUB  = 2'd2;
    localparam logic [1:0] GOP_SUB2 = 2'd3;

    // lane step operations
    localparam logic [1:0] SOP_KEEP   = 2'd0;
    localparam logic [1:0] SOP_GROW   = 2'd1;
    localparam logic [1:0] SOP_SHRINK = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] error_sample;
        logic [ERROR_WIDTH-1:0]     external_total;
    } item_t;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] out_gain_p;
        logic signed [GAIN_WIDTH-1:0] out_gain_i;
        logic signed [GAIN_WIDTH-1:0] out_gain_d;
        logic [ERROR_WIDTH-1:0]       error_sum;
        logic                         tuning_on;
        logic [PHASE_W-1:0]           phase;
        logic [GIDX_OUT_W-1:0]        gain_index;
    } result_t;

    typedef struct packed {
        logic [INIT_GAINS-1:0][GAIN_WIDTH-1:0] gain;
        logic [INIT_GAINS-1:0][GAIN_WIDTH-1:0] step;
        logic                                  start;
    } cfg_init_t;

    // one tuning move, broadcast to all lanes
    typedef struct packed {
        logic                  fire;
        logic [GIDX_W-1:0]     a_idx;
        logic [1:0]            gain_op;
        logic [1:0]            step_op;
        logic                  do_b;
        logic [GIDX_W-1:0]     b_idx;
        logic [GAIN_WIDTH-1:0] quot;
        logic                  rem_nz;
    } lane_cmd_t;

    // gain plus a signed delta, clamped to the signed gain range
    function automatic logic signed [GAIN_WIDTH-1:0] sat_gain_add(
        input logic signed [GAIN_WIDTH-1:0] g,
        input logic signed [GAIN_WIDTH+2:0] d
    );
        logic signed [GAIN_WIDTH+2:0] sum;
        logic signed [GAIN_WIDTH-1:0] res;
        sum = $signed({{3{g[GAIN_WIDTH-1]}}, g}) + d;
        if (sum[GAIN_WIDTH+2:GAIN_WIDTH-1] == '0 || sum[GAIN_WIDTH+2:GAIN_WIDTH-1] == '1)
            res = sum[GAIN_WIDTH-1:0];
        else if (sum[GAIN_WIDTH+2])
            res = $signed({1'b1, {(GAIN_WIDTH-1){1'b0}}});
        else
            res = $signed({1'b0, {(GAIN_WIDTH-1){1'b1}}});
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/twg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_if: handshake channels of the twiddle gain tuner
// Item, result and configuration write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface twg_item_if import twg_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [SAMPLE_W-1:0]  error_sample;
    logic [ERROR_WIDTH-1:0]      external_total;

    modport source (output valid, output mode, output error_sample,
                    output external_total, input ready);
    modport sink   (input valid, input mode, input error_sample,
                    input external_total, output ready);
endinterface

interface twg_result_if import twg_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [GAIN_WIDTH-1:0] out_gain_p;
    logic signed [GAIN_WIDTH-1:0] out_gain_i;
    logic signed [GAIN_WIDTH-1:0] out_gain_d;
    logic [ERROR_WIDTH-1:0]       error_sum;
    logic                         tuning_on;
    logic [PHASE_W-1:0]           phase;
    logic [GIDX_OUT_W-1:0]        gain_index;

    modport source (output valid, output out_gain_p, output out_gain_i,
                    output out_gain_d, output error_sum, output tuning_on,
                    output phase, output gain_index, input ready);
    modport sink   (input valid, input out_gain_p, input out_gain_i,
                    input out_gain_d, input error_sum, input tuning_on,
                    input phase, input gain_index, output ready);
endinterface

interface twg_cfg_if import twg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [GAIN_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/twg_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_cfg_regs: configuration registers
// Holds the starting gains, steps and enable; any write to a known register
// raises a one-cycle reload of the tuning state.
// ----------------------------------------------------------------------------
module twg_cfg_regs import twg_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    twg_cfg_if.sink       cfg,
    output cfg_init_t     init,
    output logic          load
);

    cfg_init_t init_reg;
    cfg_init_t init_next;
    logic      load_reg;
    logic      load_next;
    logic      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    // register decode
    always_comb
    begin
        init_next = init_reg;
        load_next = 1'b0;
        if (wr)
        begin
            load_next = 1'b1;
            case (cfg.index)
                REG_GAIN_P: init_next.gain[0] = cfg.data;
                REG_GAIN_I: init_next.gain[1] = cfg.data;
                REG_GAIN_D: init_next.gain[2] = cfg.data;
                REG_STEP_P: init_next.step[0] = cfg.data;
                REG_STEP_I: init_next.step[1] = cfg.data;
                REG_STEP_D: init_next.step[2] = cfg.data;
                REG_START:  init_next.start   = cfg.data[0];
                default:    load_next         = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            load_reg <= 1'b0;
        end
        else
        begin
            init_reg <= init_next;
            load_reg <= load_next;
        end
    end

    assign init = init_reg;
    assign load = load_reg;

endmodule
`default_nettype wire

// ===== rtl/twg_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_in_stage: input register
// Captures one item; refills in the same cycle the held item is taken.
// ----------------------------------------------------------------------------
module twg_in_stage import twg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    twg_item_if.sink  items,
    input  logic      take,
    output logic      held,
    output item_t     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign items.ready = !valid_reg || take;
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode           <= items.mode;
            item_reg.error_sample   <= items.error_sample;
            item_reg.external_total <= items.external_total;
        end
    end

    assign held = valid_reg;
    assign item = item_reg;

endmodule
`default_nettype wire

// ===== rtl/twg_gain_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_gain_lane: one gain and its step
// Applies the first move when it is the gain under tuning, then the opening
// raise when it is the gain tuning moves on to.
// ----------------------------------------------------------------------------
module twg_gain_lane import twg_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [GIDX_W-1:0]            lane_id,
    input  logic                         load,
    input  logic signed [GAIN_WIDTH-1:0] init_gain,
    input  logic [GAIN_WIDTH-1:0]        init_step,
    input  lane_cmd_t                    cmd,
    output logic signed [GAIN_WIDTH-1:0] gain_next,
    output logic [GAIN_WIDTH-1:0]        step_now
);

    logic signed [GAIN_WIDTH-1:0] gain_reg;
    logic [GAIN_WIDTH-1:0]        step_reg;
    logic [GAIN_WIDTH-1:0]        step_next;
    logic                         sel_a;
    logic                         sel_b;
    logic signed [GAIN_WIDTH+2:0] d_pos;
    logic signed [GAIN_WIDTH+2:0] d_neg2;
    logic signed [GAIN_WIDTH-1:0] gain_a;
    logic [GAIN_WIDTH-1:0]        step_a;
    logic [GAIN_WIDTH:0]          grow_sum;
    logic signed [GAIN_WIDTH-1:0] gain_b;

    assign sel_a = cmd.fire && (cmd.a_idx == lane_id);
    assign sel_b = cmd.fire && cmd.do_b && (cmd.b_idx == lane_id);

    assign d_pos    = $signed({3'b000, step_reg});
    assign d_neg2   = -$signed({2'b00, step_reg, 1'b0});
    assign grow_sum = {1'b0, step_reg} + {1'b0, cmd.quot};

    // first move: gain against the old step, step scaled by 11/10 or 9/10
    always_comb
    begin
        gain_a = gain_reg;
        step_a = step_reg;
        if (sel_a)
        begin
            case (cmd.gain_op)
                GOP_NONE: gain_a = gain_reg;
                GOP_ADD:  gain_a = sat_gain_add(gain_reg, d_pos);
                GOP_SUB:  gain_a = sat_gain_add(gain_reg, -d_pos);
                GOP_SUB2: gain_a = sat_gain_add(gain_reg, d_neg2);
                default:  gain_a = gain_reg;
            endcase
            case (cmd.step_op)
                SOP_KEEP:   step_a = step_reg;
                SOP_GROW:   step_a = grow_sum[GAIN_WIDTH] ? '1 : grow_sum[GAIN_WIDTH-1:0];
                SOP_SHRINK: step_a = step_reg - cmd.quot - GAIN_WIDTH'(cmd.rem_nz);
                default:    step_a = step_reg;
            endcase
        end
    end

    // opening raise of the next gain, by its own (possibly updated) step
    assign gain_b = sel_b ? sat_gain_add(gain_a, $signed({3'b000, step_a})) : gain_a;

    assign gain_next = load ? init_gain : gain_b;
    assign step_next = load ? init_step : step_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            gain_reg <= gain_next;
            step_reg <= step_next;
        end
    end

    assign step_now = step_reg;

endmodule
`default_nettype wire

// ===== rtl/twg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_core: tuning state and update
// Error accumulation, end-of-run decision, abort and continue; drives the
// gain lanes and shares one divide-by-ten multiplier among them.
// ----------------------------------------------------------------------------
module twg_core import twg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  cfg_init_t init,
    input  logic      held,
    input  item_t     item,
    input  logic      out_free,
    output logic      take,
    output result_t   result
);

    logic [ERROR_WIDTH-1:0]       best_reg;
    logic [ERROR_WIDTH-1:0]       best_next;
    logic [ERROR_WIDTH-1:0]       run_reg;
    logic [ERROR_WIDTH-1:0]       run_next;
    logic [PHASE_W-1:0]           act_reg;
    logic [PHASE_W-1:0]           act_next;
    logic [GIDX_W-1:0]            cur_reg;
    logic [GIDX_W-1:0]            cur_next;
    logic                         en_reg;
    logic                         en_next;

    logic signed [GAIN_WIDTH-1:0] gain_nx  [NUM_GAINS];
    logic [GAIN_WIDTH-1:0]        step_now [NUM_GAINS];
    logic signed [GAIN_WIDTH-1:0] out_g    [INIT_GAINS];
    lane_cmd_t                    cmd;

    logic [GAIN_WIDTH-1:0]        step_c;
    logic [2*GAIN_WIDTH-1:0]      div_prod;
    logic [GAIN_WIDTH-1:0]        quot;
    logic [GAIN_WIDTH-1:0]        quot10;
    logic signed [SQUARE_W-1:0]   sq_s;
    logic [ERROR_WIDTH:0]         acc_sum;
    logic [ERROR_WIDTH-1:0]       total;
    logic                         improve;
    logic                         grow;
    logic [PHASE_W-1:0]           act2;
    logic [GIDX_W-1:0]            nxt_idx;

    assign take = held && out_free && !load;

    // shared step/10 of the gain under tuning
    assign step_c   = step_now[cur_reg];
    assign div_prod = (2*GAIN_WIDTH)'(step_c) * (2*GAIN_WIDTH)'(DIV10_MUL);
    assign quot     = GAIN_WIDTH'(div_prod[2*GAIN_WIDTH-1:DIV10_SHIFT]);
    assign quot10   = (quot << 3) + (quot << 1);

    // squared sample, saturating accumulate
    assign sq_s    = item.error_sample * item.error_sample;
    assign acc_sum = {1'b0, run_reg} + (ERROR_WIDTH+1)'($unsigned(sq_s));

    assign total   = (item.mode == MODE_END_EXT) ? item.external_total : run_reg;
    assign improve = total < best_reg;
    assign grow    = improve && (act_reg != ACT_INIT);
    assign act2    = grow ? ACT_INCREASE : act_reg;
    assign nxt_idx = (cur_reg == GIDX_W'(NUM_GAINS - 1)) ? '0 : cur_reg + 1'b1;

    // next state and lane command for the held item
    always_comb
    begin
        best_next   = best_reg;
        run_next    = run_reg;
        act_next    = act_reg;
        cur_next    = cur_reg;
        en_next     = en_reg;
        cmd.fire    = take;
        cmd.a_idx   = cur_reg;
        cmd.gain_op = GOP_NONE;
        cmd.step_op = SOP_KEEP;
        cmd.do_b    = 1'b0;
        cmd.b_idx   = nxt_idx;
        cmd.quot    = quot;
        cmd.rem_nz  = (quot10 != step_c);
        case (item.mode)
            MODE_SAMPLE:
            begin
                run_next = acc_sum[ERROR_WIDTH] ? '1 : acc_sum[ERROR_WIDTH-1:0];
            end
            MODE_END_INT, MODE_END_EXT:
            begin
                run_next = '0;
                if (en_reg)
                begin
                    if (improve)
                        best_next = total;
                    cmd.step_op = grow ? SOP_GROW : SOP_KEEP;
                    if (act2 == ACT_DECREASE)
                    begin
                        cmd.gain_op = GOP_SUB2;
                        act_next    = ACT_REVERT;
                    end
                    else
                    begin
                        if (act2 == ACT_REVERT)
                        begin
                            cmd.gain_op = GOP_ADD;
                            cmd.step_op = SOP_SHRINK;
                        end
                        cmd.do_b  = 1'b1;
                        cmd.b_idx = (act2 == ACT_INIT) ? cur_reg : nxt_idx;
                        cur_next  = cmd.b_idx;
                        act_next  = ACT_DECREASE;
                    end
                end
            end
            MODE_ABORT:
            begin
                en_next  = 1'b0;
                run_next = '0;
                act_next = ACT_INIT;
                case (act_reg)
                    ACT_REVERT:   cmd.gain_op = GOP_ADD;
                    ACT_DECREASE: cmd.gain_op = GOP_SUB;
                    default:      cmd.gain_op = GOP_NONE;
                endcase
            end
            MODE_CONTINUE:
            begin
                en_next = 1'b1;
            end
            default:
            begin
                en_next = en_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '1;
            run_reg  <= '0;
            act_reg  <= ACT_INIT;
            cur_reg  <= '0;
            en_reg   <= 1'b0;
        end
        else if (load)
        begin
            best_reg <= '1;
            run_reg  <= '0;
            act_reg  <= ACT_INIT;
            cur_reg  <= '0;
            en_reg   <= init.start;
        end
        else if (take)
        begin
            best_reg <= best_next;
            run_reg  <= run_next;
            act_reg  <= act_next;
            cur_reg  <= cur_next;
            en_reg   <= en_next;
        end
    end

    // gain lanes
    genvar k;
    generate
        for (k = 0; k < NUM_GAINS; k++)
        begin : g_lane
            logic signed [GAIN_WIDTH-1:0] ig;
            logic [GAIN_WIDTH-1:0]        is;
            if (k < INIT_GAINS)
            begin : g_init
                assign ig = $signed(init.gain[k]);
                assign is = init.step[k];
            end
            else
            begin : g_zero
                assign ig = '0;
                assign is = '0;
            end
            twg_gain_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .lane_id   (GIDX_W'(k)),
                .load      (load),
                .init_gain (ig),
                .init_step (is),
                .cmd       (cmd),
                .gain_next (gain_nx[k]),
                .step_now  (step_now[k])
            );
        end
        for (k = 0; k < INIT_GAINS; k++)
        begin : g_out
            if (k < NUM_GAINS)
            begin : g_live
                assign out_g[k] = gain_nx[k];
            end
            else
            begin : g_none
                assign out_g[k] = '0;
            end
        end
    endgenerate

    // state after the item
    assign result.out_gain_p = out_g[0];
    assign result.out_gain_i = out_g[1];
    assign result.out_gain_d = out_g[2];
    assign result.error_sum  = run_next;
    assign result.tuning_on  = en_next;
    assign result.phase      = act_next;
    assign result.gain_index = GIDX_OUT_W'(cur_next);

endmodule
`default_nettype wire

// ===== rtl/twg_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_out_stage: result register
// Holds one result until taken; frees in the same cycle it is taken.
// ----------------------------------------------------------------------------
module twg_out_stage import twg_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    twg_result_if.source  results,
    input  logic          load_res,
    input  result_t       result,
    output logic          out_free
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || results.ready;

    always_comb
    begin
        if (load_res)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load_res)
            res_reg <= result;
    end

    assign results.valid      = valid_reg;
    assign results.out_gain_p = res_reg.out_gain_p;
    assign results.out_gain_i = res_reg.out_gain_i;
    assign results.out_gain_d = res_reg.out_gain_d;
    assign results.error_sum  = res_reg.error_sum;
    assign results.tuning_on  = res_reg.tuning_on;
    assign results.phase      = res_reg.phase;
    assign results.gain_index = res_reg.gain_index;

endmodule
`default_nettype wire

// ===== rtl/twiddle_gain_tuner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twiddle_gain_tuner: PID gain tuner by twiddle coordinate descent
// Accumulates squared error per run and makes one tuning move per end-of-run item while tuning is on.
// ----------------------------------------------------------------------------
// Each item gives exactly one result showing the tuner state after that item.
// An item passes through the input register, then the result register, on its way
// to a result, and a new item is accepted every cycle as long as results are
// taken and no reload is under way; one pass holds the 16x16 square-accumulate,
// the 32x32 multiply that forms step/10 for the 11/10 and 9/10 step scaling,
// and the saturating gain adders. A configuration write reloads gains, steps
// and the run state in the following cycle; items wait during that cycle.
module twiddle_gain_tuner import twg_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    twg_item_if.sink      items,
    twg_result_if.source  results,
    twg_cfg_if.sink       cfg
);

    cfg_init_t init;
    logic      load;
    logic      held;
    item_t     item;
    logic      take;
    logic      out_free;
    result_t   result;

    twg_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .init  (init),
        .load  (load)
    );

    twg_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .items (items),
        .take  (take),
        .held  (held),
        .item  (item)
    );

    twg_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .init     (init),
        .held     (held),
        .item     (item),
        .out_free (out_free),
        .take     (take),
        .result   (result)
    );

    twg_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .results  (results),
        .load_res (take),
        .result   (result),
        .out_free (out_free)
    );

endmodule
`default_nettype wire

// ===== rtl/twg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_checker: port-level checks of the twiddle gain tuner
// Result channel holding, tuning phase consistency and gain index range, bound to the top.
// ----------------------------------------------------------------------------
module twg_checker import twg_pkg::*; (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [GAIN_WIDTH-1:0] res_gain_p,
    input logic [ERROR_WIDTH-1:0]       res_error_sum,
    input logic                         res_tuning_on,
    input logic [PHASE_W-1:0]           res_phase,
    input logic [GIDX_OUT_W-1:0]        res_gain_index
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_gain_p)
            && $stable(res_error_sum))
        else $error("result changed while stalled");

    // an end of run with tuning on leaves decrease or revert pending, never increase
    a_no_increase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_phase != ACT_INCREASE)
        else $error("increase shown as next action");

    // tuning stops only through abort or reload, both of which reset phase
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_tuning_on |-> res_phase == ACT_INIT)
        else $error("phase pending while tuning off");

    // gain under tuning stays within the gain count
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> int'(res_gain_index) < NUM_GAINS)
        else $error("gain index out of range");

endmodule

bind twiddle_gain_tuner twg_checker u_twg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_gain_p     (results.out_gain_p),
    .res_error_sum  (results.error_sum),
    .res_tuning_on  (results.tuning_on),
    .res_phase      (results.phase),
    .res_gain_index (results.gain_index)
);
`default_nettype wire

// ===== test/twg_tuner_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_tuner_checker: result predictor and scoreboard for twiddle_gain_tuner
// Watches the item, result and configuration channels, keeps its own copy of
// the tuner state, predicts one result per accepted item and compares every
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module twg_tuner_checker import twg_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    twg_item_if   items,
    twg_result_if results,
    twg_cfg_if    cfg,
    output int    pending,
    output int    fail_count
);

    localparam logic [ERROR_WIDTH-1:0] ERR_ALL_ONES = '1;
    localparam longint GAIN_HI = (longint'(1) <<< (GAIN_WIDTH - 1)) - 1;
    localparam longint GAIN_LO = -GAIN_HI - 1;
    localparam longint unsigned STEP_HI = (longint'(1) <<< GAIN_WIDTH) - 1;

    // register copies and predicted tuner state
    logic [GAIN_WIDTH-1:0]        reg_copy [NUM_CFG];
    logic signed [GAIN_WIDTH-1:0] gain_est [NUM_GAINS];
    logic [GAIN_WIDTH-1:0]        step_est [NUM_GAINS];
    logic [ERROR_WIDTH-1:0]       best_total;
    logic [ERROR_WIDTH-1:0]       run_total;
    logic [PHASE_W-1:0]           next_act;
    int                           cur_idx;
    logic                         tune_en;

    result_t expected_q [$];

    function automatic logic signed [GAIN_WIDTH-1:0] clamp_gain(input longint v);
        if (v > GAIN_HI)
            return GAIN_WIDTH'(GAIN_HI);
        if (v < GAIN_LO)
            return GAIN_WIDTH'(GAIN_LO);
        return GAIN_WIDTH'(v);
    endfunction

    // floor(step * num / 10), clamped to the unsigned step range
    function automatic logic [GAIN_WIDTH-1:0] scaled_step(input logic [GAIN_WIDTH-1:0] s,
                                                          input int unsigned num);
        longint unsigned prod;
        prod = (longint'(s) * num) / 10;
        if (prod > STEP_HI)
            return '1;
        return GAIN_WIDTH'(prod);
    endfunction

    function automatic longint step_of(input int c);
        return longint'({32'b0, step_est[c]});
    endfunction

    task automatic report_fail(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // full reload from the register copies
    task automatic load_setup();
        for (int k = 0; k < NUM_GAINS; k++)
        begin
            gain_est[k] = (k < INIT_GAINS) ? reg_copy[REG_GAIN_P + k] : '0;
            step_est[k] = (k < INIT_GAINS) ? reg_copy[REG_STEP_P + k] : '0;
        end
        best_total = ERR_ALL_ONES;
        run_total  = '0;
        next_act   = ACT_INIT;
        cur_idx    = 0;
        tune_en    = reg_copy[REG_START][0];
    endtask

    // end of run: compare with the best total and make the next move
    task automatic finish_run(input logic [ERROR_WIDTH-1:0] total);
        int c;
        c = cur_idx;
        if (tune_en)
        begin
            if (total < best_total)
            begin
                best_total = total;
                if (next_act != ACT_INIT)
                begin
                    step_est[c] = scaled_step(step_est[c], 11);
                    next_act    = ACT_INCREASE;
                end
            end
            if (next_act == ACT_DECREASE)
            begin
                gain_est[c] = clamp_gain(longint'(gain_est[c]) - 2 * step_of(c));
                next_act    = ACT_REVERT;
            end
            else
            begin
                if (next_act == ACT_REVERT)
                begin
                    gain_est[c] = clamp_gain(longint'(gain_est[c]) + step_of(c));
                    step_est[c] = scaled_step(step_est[c], 9);
                end
                if (next_act != ACT_INIT)
                    c = (c + 1) % NUM_GAINS;
                gain_est[c] = clamp_gain(longint'(gain_est[c]) + step_of(c));
                next_act    = ACT_DECREASE;
            end
            cur_idx = c;
        end
        run_total = '0;
    endtask

    // undo the move in progress and stop tuning
    task automatic abort_run();
        int c;
        c       = cur_idx;
        tune_en = 1'b0;
        if (next_act == ACT_REVERT)
            gain_est[c] = clamp_gain(longint'(gain_est[c]) + step_of(c));
        else if (next_act == ACT_DECREASE)
            gain_est[c] = clamp_gain(longint'(gain_est[c]) - step_of(c));
        next_act  = ACT_INIT;
        run_total = '0;
    endtask

    task automatic predict_item(input item_t it, output result_t r);
        longint                 e;
        logic [ERROR_WIDTH-1:0] sq;
        case (it.mode)
            MODE_SAMPLE:
            begin
                e  = longint'($signed(it.error_sample));
                sq = ERROR_WIDTH'(e * e);
                if (run_total > ERR_ALL_ONES - sq)
                    run_total = ERR_ALL_ONES;
                else
                    run_total = run_total + sq;
            end
            MODE_END_INT:  finish_run(run_total);
            MODE_END_EXT:  finish_run(it.external_total);
            MODE_ABORT:    abort_run();
            MODE_CONTINUE: tune_en = 1'b1;
            default:       ;
        endcase
        r.out_gain_p = (NUM_GAINS > 0) ? gain_est[0] : '0;
        r.out_gain_i = (NUM_GAINS > 1) ? gain_est[1] : '0;
        r.out_gain_d = (NUM_GAINS > 2) ? gain_est[2] : '0;
        r.error_sum  = run_total;
        r.tuning_on  = tune_en;
        r.phase      = next_act;
        r.gain_index = GIDX_OUT_W'(cur_idx);
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.out_gain_p = results.out_gain_p;
        got.out_gain_i = results.out_gain_i;
        got.out_gain_d = results.out_gain_d;
        got.error_sum  = results.error_sum;
        got.tuning_on  = results.tuning_on;
        got.phase      = results.phase;
        got.gain_index = results.gain_index;
        if (expected_q.size() == 0)
        begin
            report_fail($sformatf("result with nothing expected: %h", got));
            return;
        end
        want = expected_q.pop_front();
        if (got.out_gain_p !== want.out_gain_p)
            report_fail($sformatf("out_gain_p %h, expected %h", got.out_gain_p, want.out_gain_p));
        if (got.out_gain_i !== want.out_gain_i)
            report_fail($sformatf("out_gain_i %h, expected %h", got.out_gain_i, want.out_gain_i));
        if (got.out_gain_d !== want.out_gain_d)
            report_fail($sformatf("out_gain_d %h, expected %h", got.out_gain_d, want.out_gain_d));
        if (got.error_sum !== want.error_sum)
            report_fail($sformatf("error_sum %h, expected %h", got.error_sum, want.error_sum));
        if (got.tuning_on !== want.tuning_on)
            report_fail($sformatf("tuning_on %b, expected %b", got.tuning_on, want.tuning_on));
        if (got.phase !== want.phase)
            report_fail($sformatf("phase %0d, expected %0d", got.phase, want.phase));
        if (got.gain_index !== want.gain_index)
            report_fail($sformatf("gain_index %0d, expected %0d", got.gain_index,
                                  want.gain_index));
    endtask

    // channel monitor: results first, then register writes, then new items
    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t exp_r;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CFG; k++)
                reg_copy[k] = '0;
            load_setup();
            expected_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
                check_result();
            // a write to an unknown index is ignored and reloads nothing
            if (cfg.valid && cfg.ready && cfg.index < NUM_CFG)
            begin
                reg_copy[cfg.index] = cfg.data;
                load_setup();
            end
            if (items.valid && items.ready)
            begin
                it.mode           = items.mode;
                it.error_sample   = items.error_sample;
                it.external_total = items.external_total;
                predict_item(it, exp_r);
                expected_q.push_back(exp_r);
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== test/twiddle_gain_tuner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twiddle_gain_tuner_tb: top level testbench of the twiddle gain tuner
// Drives directed and random items under several register settings and
// handshake idling patterns; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module twiddle_gain_tuner_tb;
    import twg_pkg::*;

    localparam int IDLE_LIMIT     = 2000;    // cycles with no channel moving
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
    localparam int MAX_GAP        = 40;
    localparam int RUN_ITEMS      = 280;     // random items per phase
    localparam int MODE_UNUSED_HI = (1 << MODE_W) - 1;

    logic clk = 1'b0;
    logic rst_n;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int chk_pending;
    int chk_fails;

    twg_item_if   item_ch ();
    twg_result_if res_ch ();
    twg_cfg_if    cfg_ch ();

    twiddle_gain_tuner DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    twg_tuner_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (item_ch),
        .results    (res_ch),
        .cfg        (cfg_ch),
        .pending    (chk_pending),
        .fail_count (chk_fails)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles in which no channel moves
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic item_t mk_item(input logic [MODE_W-1:0] m,
                                      input logic [SAMPLE_W-1:0] e,
                                      input logic [ERROR_WIDTH-1:0] t);
        item_t it;
        it.mode           = m;
        it.error_sample   = e;
        it.external_total = t;
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 16'h7FFF;
        if (pick < 10)
            return 16'h8000;
        if (pick < 15)
            return '0;
        if (pick < 20)
            return '1;
        return SAMPLE_W'($urandom());
    endfunction

    // mostly small totals so that improvements keep happening
    function automatic logic [ERROR_WIDTH-1:0] rand_total();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '1;
        if (pick < 20)
            return '0;
        if (pick < 50)
            return ERROR_WIDTH'({$urandom(), $urandom()});
        return ERROR_WIDTH'($urandom_range(32'h0010_0000, 0));
    endfunction

    // one item, after a random sender gap
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.mode           <= it.mode;
        item_ch.error_sample   <= it.error_sample;
        item_ch.external_total <= it.external_total;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // stop offering items and wait until every result is in
    task automatic wait_results_done();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [GAIN_WIDTH-1:0] val, input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    // write every register while the block is idle
    task automatic load_setting(input cfg_init_t s);
        logic [GAIN_WIDTH-1:0] start_word;
        start_word    = $urandom();
        start_word[0] = s.start;
        wait_results_done();
        repeat (4) @(posedge clk);
        write_reg(REG_GAIN_P, s.gain[0], 1'b0);
        write_reg(REG_GAIN_I, s.gain[1], 1'b0);
        write_reg(REG_GAIN_D, s.gain[2], 1'b0);
        write_reg(REG_STEP_P, s.step[0], 1'b0);
        write_reg(REG_STEP_I, s.step[1], 1'b0);
        write_reg(REG_STEP_D, s.step[2], 1'b0);
        write_reg(REG_START, start_word, 1'b1);
    endtask

    // a run of samples closed by an end item, sometimes by another command
    task automatic send_run(output int n_sent);
        int    n;
        int    pick;
        item_t it;
        n = $urandom_range(6, 0);
        for (int k = 0; k < n; k++)
            send_item(mk_item(MODE_SAMPLE, rand_sample(), rand_total()));
        it   = mk_item(MODE_END_INT, rand_sample(), rand_total());
        pick = $urandom_range(99);
        if (pick >= 95)
            it.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_CONTINUE + 1));
        else if (pick >= 88)
            it.mode = MODE_CONTINUE;
        else if (pick >= 80)
            it.mode = MODE_ABORT;
        else if (pick >= 45)
            it.mode = MODE_END_EXT;
        send_item(it);
        n_sent = n + 1;
    endtask

    initial
    begin
        cfg_init_t s;
        int        sent;
        int        n;
        bit        held;
        bit        paused;

        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.mode           <= MODE_SAMPLE;
        item_ch.error_sample   <= '0;
        item_ch.external_total <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_GAIN_P;
        cfg_ch.data            <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: moderate gains, tuning enabled
        s.gain[0] = 32'h0100_0000;
        s.gain[1] = 32'h0080_0000;
        s.gain[2] = 32'h0040_0000;
        s.step[0] = 32'h0020_0000;
        s.step[1] = 32'h0010_0000;
        s.step[2] = 32'h0008_0000;
        s.start   = 1'b1;
        load_setting(s);
        send_item(mk_item(MODE_SAMPLE, 16'h7FFF, '1));
        send_item(mk_item(MODE_SAMPLE, 16'h8000, '0));
        send_item(mk_item(MODE_SAMPLE, 16'h0000, '1));
        send_item(mk_item(MODE_SAMPLE, 16'hFFFF, '0));
        send_item(mk_item(MODE_END_INT, '0, '0));      // first run sets the best
        send_item(mk_item(MODE_SAMPLE, 16'h0100, '0));
        send_item(mk_item(MODE_END_EXT, '0, '1));      // no gain: decrease
        send_item(mk_item(MODE_END_EXT, '0, '1));      // no gain: restore, next gain
        send_item(mk_item(MODE_END_EXT, '0, '0));      // improvement: step grows
        send_item(mk_item(MODE_END_EXT, '0, '0));      // equal to best: no gain
        send_item(mk_item(MODE_ABORT, '0, '0));        // undo a decrease
        send_item(mk_item(MODE_END_INT, '0, '0));      // end while disabled
        send_item(mk_item(MODE_SAMPLE, 16'h1234, '0));
        send_item(mk_item(MODE_CONTINUE, '0, '0));
        send_item(mk_item(MODE_END_EXT, '0, '1));
        send_item(mk_item(MODE_END_EXT, '0, '1));
        send_item(mk_item(MODE_ABORT, '0, '0));        // undo a decrease
        send_item(mk_item(MODE_CONTINUE, '0, '0));
        send_item(mk_item(MODE_W'(MODE_CONTINUE + 1), 16'h5A5A, '1));
        send_item(mk_item(MODE_W'(MODE_CONTINUE + 2), 16'hA5A5, '0));
        send_item(mk_item(MODE_W'(MODE_UNUSED_HI), '1, '1));
        send_item(mk_item(MODE_ABORT, '0, '0));        // abort from init
        send_item(mk_item(MODE_CONTINUE, '0, '0));

        // random phases, one register setting and idling pattern each
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    s.gain[0] = 32'h7FFF_FFFF;
                    s.gain[1] = 32'h8000_0000;
                    s.gain[2] = 32'h7FFF_FFFF;
                    s.step[0] = 32'hFFFF_FFFF;
                    s.step[1] = 32'h8000_0000;
                    s.step[2] = 32'hFFFF_FFF0;
                    s.start   = 1'b1;
                end
                1:
                begin
                    s.gain[0] = '0;
                    s.gain[1] = '0;
                    s.gain[2] = '0;
                    s.step[0] = 32'd1;
                    s.step[1] = '0;
                    s.step[2] = 32'd3;
                    s.start   = 1'b0;
                end
                2:
                begin
                    s.gain[0] = $urandom();
                    s.gain[1] = $urandom();
                    s.gain[2] = $urandom();
                    s.step[0] = $urandom() >> 4;
                    s.step[1] = $urandom() >> 8;
                    s.step[2] = $urandom();
                    s.start   = 1'b1;
                end
                default:
                begin
                    s.gain[0] = 32'h8000_0000;
                    s.gain[1] = 32'h8000_0001;
                    s.gain[2] = 32'hFFFF_FFFF;
                    s.step[0] = 32'h0100_0000;
                    s.step[1] = 32'h0000_000A;
                    s.step[2] = 32'h4000_0000;
                    s.start   = 1'b1;
                end
            endcase
            load_setting(s);
            idle_pct   = (p == 1) ? 64 : (p == 3) ? 38 : 0;
            stall_pct <= (p == 2) ? 64 : (p == 3) ? 38 : 0;
            sent   = 0;
            held   = 1'b0;
            paused = 1'b0;
            while (sent < RUN_ITEMS)
            begin
                // fill the block behind a long receiver hold-off
                if (p == 0 && sent >= 100 && !held)
                begin
                    hold_reqs <= hold_reqs + 1;
                    held = 1'b1;
                end
                // pause the sender until all results are back
                if (p == 0 && sent >= 200 && !paused)
                begin
                    wait_results_done();
                    paused = 1'b1;
                end
                send_run(n);
                sent += n;
            end
        end

        wait_results_done();
        repeat (8) @(posedge clk);
        if (chk_fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
